[rtl/aarm_pkg.sv]
// Shared constants, types and helpers of the axis-angle rotation matrix block.
`timescale 1ns / 1ps

package aarm_pkg;

    // Scaled axis magnitude width and internal Q30 widths
    localparam int MAG_W = 32;
    localparam int Z_W   = 35;
    localparam int Q_W   = 34;

    localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [Z_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [Q_W-1:0] Q30_ONE     = 34'sd1073741824;

    localparam logic [31:0] ATAN_HEAD [10] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149
    };

    // One classified request handed from the front end to the back end
    typedef struct packed {
        logic [2:0][MAG_W-1:0]  mag;   // |component| scaled by the shift that puts the largest into (2^30, 2^31]
        logic [2:0]             neg;
        logic                   zero;
        logic                   flip;  // angle folded by pi
        logic signed [Z_W-1:0]  z;     // folded angle, Q30
    } aarm_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQSUM,
        ST_SQRT,
        ST_DIV,
        ST_CORDIC,
        ST_MUL,
        ST_EMIT
    } aarm_state_t;

    // Product schedule of the matrix terms
    typedef enum logic [3:0] {
        OP_SQ0, OP_SQ1, OP_SQ2,
        OP_D0,  OP_D1,  OP_D2,
        OP_P01, OP_P02, OP_P12,
        OP_A01, OP_A02, OP_A12,
        OP_S2,  OP_S1,  OP_S0
    } aarm_op_t;

    function automatic logic signed [Q_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Q_W-1:0] r;
        if (i < 5'd10) begin
            r = Q_W'(ATAN_HEAD[i[3:0]]);
        end
        else if (i <= 5'd30) begin
            r = Q_W'(1) << (5'd30 - i);
        end
        else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

[rtl/aarm_if.sv]
// Request and row channel interfaces of the rotation matrix block.
`timescale 1ns / 1ps

interface aarm_axis_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] axis_x;
    logic signed [DATA_WIDTH-1:0] axis_y;
    logic signed [DATA_WIDTH-1:0] axis_z;
    logic signed [DATA_WIDTH-1:0] angle;

    modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
    modport sink   (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aarm_row_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   row_index;
    logic signed [DATA_WIDTH-1:0] col0;
    logic signed [DATA_WIDTH-1:0] col1;
    logic signed [DATA_WIDTH-1:0] col2;
    logic signed [DATA_WIDTH-1:0] col3;
    logic                         zero_axis;
    logic                         last_row;

    modport source (output valid, row_index, col0, col1, col2, col3, zero_axis, last_row,
                    input ready);
    modport sink   (input valid, row_index, col0, col1, col2, col3, zero_axis, last_row,
                    output ready);
endinterface

[rtl/aarm_front.sv]
// Front end: takes requests, finds the axis scale and folds the angle.
`timescale 1ns / 1ps

module aarm_front #(
    parameter int DATA_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    aarm_axis_if.sink         axis,
    output logic              job_valid,
    input  logic              job_ready,
    output aarm_pkg::aarm_job_t job
);
    import aarm_pkg::*;

    localparam int ZSH = 33 - DATA_WIDTH;

    logic                         s1_valid_reg;
    logic [DATA_WIDTH-1:0]        s1_mag_reg [3];
    logic [2:0]                   s1_neg_reg;
    logic [DATA_WIDTH-1:0]        s1_mx_reg;
    logic signed [DATA_WIDTH-1:0] s1_angle_reg;

    logic [DATA_WIDTH-1:0]        mag_x, mag_y, mag_z, mx;
    logic [DATA_WIDTH-1:0]        mxm1;
    logic [4:0]                   msb, clog, k;
    logic signed [Z_W-1:0]        z0;

    // stage 1: magnitudes and largest magnitude
    assign mag_x = axis.axis_x[DATA_WIDTH-1] ? (~axis.axis_x + 1'b1) : axis.axis_x;
    assign mag_y = axis.axis_y[DATA_WIDTH-1] ? (~axis.axis_y + 1'b1) : axis.axis_y;
    assign mag_z = axis.axis_z[DATA_WIDTH-1] ? (~axis.axis_z + 1'b1) : axis.axis_z;

    always_comb
    begin
        mx = mag_x;
        if (mag_y > mx)
        begin
            mx = mag_y;
        end
        if (mag_z > mx)
        begin
            mx = mag_z;
        end
    end

    assign axis.ready = !s1_valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (axis.ready)
        begin
            s1_valid_reg <= axis.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (axis.ready && axis.valid)
        begin
            s1_mag_reg[0] <= mag_x;
            s1_mag_reg[1] <= mag_y;
            s1_mag_reg[2] <= mag_z;
            s1_neg_reg    <= {axis.axis_z[DATA_WIDTH-1], axis.axis_y[DATA_WIDTH-1],
                              axis.axis_x[DATA_WIDTH-1]};
            s1_mx_reg     <= mx;
            s1_angle_reg  <= axis.angle;
        end
    end

    // stage 2: shift that puts the largest magnitude into (2^30, 2^31]
    assign mxm1 = s1_mx_reg - 1'b1;

    always_comb
    begin
        msb = '0;
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            if (mxm1[b])
            begin
                msb = 5'(b);
            end
        end
    end

    assign clog = (s1_mx_reg <= DATA_WIDTH'(1)) ? 5'd0 : msb + 5'd1;
    assign k    = 5'd31 - clog;
    assign z0   = Z_W'(s1_angle_reg) <<< ZSH;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job.mag[i] = MAG_W'(s1_mag_reg[i]) << k;
        end
        job.neg  = s1_neg_reg;
        job.zero = (s1_mx_reg == '0);
        priority if (z0 > Q30_HALF_PI)
        begin
            job.z    = z0 - Q30_PI;
            job.flip = 1'b1;
        end
        else if (z0 < -Q30_HALF_PI)
        begin
            job.z    = z0 + Q30_PI;
            job.flip = 1'b1;
        end
        else
        begin
            job.z    = z0;
            job.flip = 1'b0;
        end
    end

    assign job_valid = s1_valid_reg;

endmodule

[rtl/aarm_queue.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module aarm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  aarm_pkg::aarm_job_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output aarm_pkg::aarm_job_t rd_data
);
    import aarm_pkg::*;

    aarm_job_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/aarm_back.sv]
// Back end: length, unit axis, CORDIC sine/cosine, matrix products and row output.
`timescale 1ns / 1ps

module aarm_back #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  aarm_pkg::aarm_job_t job,
    aarm_row_if.source          matrix
);
    import aarm_pkg::*;

    // constant helpers, run at elaboration only
    function automatic logic [63:0] c_isqrt(input logic [63:0] v);
        logic [63:0] r, b, w;
        r = '0;
        b = 64'd1 << 62;
        w = v;
        for (int j = 0; j < 32; j++)
        begin
            if (b > w)
            begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++)
        begin
            if (b != 0)
            begin
                if (w >= r + b)
                begin
                    w = w - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] c_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q, r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--)
        begin
            r = {r[62:0], n[j]};
            if (r >= d)
            begin
                r    = r - d;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] c_inv_gain();
        logic [63:0] p, sq, s;
        p = 64'd1073741824;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sq = 64'd1 << 60;
            if (2 * i <= 60)
            begin
                sq = sq + (64'd1 << (60 - 2 * i));
            end
            s = c_isqrt(sq);
            p = c_div((p << 30) + (s >> 1), s);
        end
        return p;
    endfunction

    localparam logic signed [Q_W-1:0] INV_GAIN = Q_W'(c_inv_gain());
    localparam logic [4:0]            LAST_STEP = 5'(CORDIC_STEPS - 1);

    // output rounding and saturation
    localparam int                 SH  = 32 - DATA_WIDTH;
    localparam logic signed [35:0] RND = 36'sd1 <<< SH;
    localparam logic signed [35:0] HI  = (36'sd1 <<< (DATA_WIDTH - 1)) - 36'sd1;
    localparam logic signed [35:0] LO  = -HI - 36'sd1;
    localparam logic [DATA_WIDTH-1:0] OUT_ONE = DATA_WIDTH'(1) << (DATA_WIDTH - 2);

    function automatic logic [DATA_WIDTH-1:0] to_out(input logic signed [Q_W-1:0] v);
        logic signed [35:0] w;
        w = ((36'(v) <<< 1) + RND) >>> (SH + 1);
        if (w > HI)
        begin
            w = HI;
        end
        if (w < LO)
        begin
            w = LO;
        end
        return w[DATA_WIDTH-1:0];
    endfunction

    aarm_state_t state_reg, state_next;
    aarm_op_t    op_reg, op_next;
    logic        phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic [1:0]  erow_reg, erow_next;
    aarm_job_t   job_reg, job_next;

    logic signed [Q_W-1:0]   mul_a, mul_b;
    logic signed [2*Q_W-1:0] prod_reg, prod_rnd;

    logic [63:0] sum_reg, sum_next;
    logic [63:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next, rem2, trial;
    logic [31:0] root_reg, root_next;

    logic [61:0] div_num;
    logic [31:0] drem_reg, drem_next;
    logic [32:0] drem2, ddiff;
    logic        dge;
    logic [30:0] dnum_reg, dnum_next;
    logic [30:0] quo_reg, quo_next, quo_fin, quo_cap;
    logic signed [Q_W-1:0] u_val;
    logic        u_wr;
    logic signed [Q_W-1:0] u_reg [3];

    logic signed [Q_W-1:0] x_reg, x_next, y_reg, y_next, cx, cy, at;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic signed [Q_W-1:0] cs_reg, cs_next, sn_reg, sn_next, t_val;

    logic                  tmp_wr;
    logic signed [Q_W-1:0] tmp_reg [15];

    logic signed [Q_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [Q_W-1:0] e0, e1, e2;
    logic                  load_out;

    logic                  out_valid_reg;
    logic [1:0]            row_reg;
    logic [DATA_WIDTH-1:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic                  zero_reg, last_reg;

    // shared datapath pieces
    assign rem2     = {rem_reg[33:0], rad_reg[63:62]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign div_num  = {job_reg.mag[comp_reg], 30'b0} + 62'(root_reg >> 1);
    assign drem2    = {drem_reg, dnum_reg[30]};
    assign dge      = (drem2 >= {1'b0, root_reg});
    assign ddiff    = drem2 - {1'b0, root_reg};
    assign quo_fin  = {quo_reg[29:0], dge};
    assign quo_cap  = (quo_fin > 31'd1073741824) ? 31'd1073741824 : quo_fin;
    assign u_val    = job_reg.neg[comp_reg] ? -$signed({3'b000, quo_cap})
                                            : $signed({3'b000, quo_cap});
    assign cx       = x_reg >>> cnt_reg;
    assign cy       = y_reg >>> cnt_reg;
    assign at       = atan_q30(cnt_reg);
    assign t_val    = Q30_ONE - cs_reg;
    assign prod_rnd = prod_reg + (2*Q_W)'(64'd536870912);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        erow_next  = erow_reg;
        job_next   = job_reg;
        sum_next   = sum_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        drem_next  = drem_reg;
        dnum_next  = dnum_reg;
        quo_next   = quo_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cs_next    = cs_reg;
        sn_next    = sn_reg;
        mul_a      = '0;
        mul_b      = '0;
        u_wr       = 1'b0;
        tmp_wr     = 1'b0;
        load_out   = 1'b0;
        job_ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    job_next   = job;
                    x_next     = INV_GAIN;
                    y_next     = '0;
                    z_next     = job.z;
                    cnt_next   = '0;
                    sum_next   = '0;
                    erow_next  = '0;
                    state_next = job.zero ? ST_EMIT : ST_SQSUM;
                end
            end

            ST_SQSUM:
            begin
                if (cnt_reg < 5'd3)
                begin
                    mul_a = $signed({2'b00, job_reg.mag[cnt_reg[1:0]]});
                    mul_b = $signed({2'b00, job_reg.mag[cnt_reg[1:0]]});
                end
                if (cnt_reg != 5'd0)
                begin
                    sum_next = sum_reg + prod_reg[63:0];
                end
                if (cnt_reg == 5'd3)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                    rad_next   = sum_next;
                    rem_next   = '0;
                    root_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end

            ST_SQRT:
            begin
                rad_next = rad_reg << 2;
                if (rem2 >= trial)
                begin
                    rem_next  = rem2 - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem2;
                    root_next = {root_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    comp_next  = '0;
                end
            end

            ST_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    drem_next = {1'b0, div_num[61:31]};
                    dnum_next = div_num[30:0];
                    quo_next  = '0;
                end
                else
                begin
                    drem_next = dge ? ddiff[31:0] : drem2[31:0];
                    dnum_next = dnum_reg << 1;
                    quo_next  = quo_fin;
                    if (cnt_reg == 5'd31)
                    begin
                        u_wr     = 1'b1;
                        cnt_next = '0;
                        if (comp_reg == 2'd2)
                        begin
                            state_next = ST_CORDIC;
                        end
                        else
                        begin
                            comp_next = comp_reg + 2'd1;
                        end
                    end
                end
            end

            ST_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - cy;
                    y_next = y_reg + cx;
                    z_next = z_reg - Z_W'(at);
                end
                else
                begin
                    x_next = x_reg + cy;
                    y_next = y_reg - cx;
                    z_next = z_reg + Z_W'(at);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    cs_next    = job_reg.flip ? -x_next : x_next;
                    sn_next    = job_reg.flip ? -y_next : y_next;
                    state_next = ST_MUL;
                    op_next    = OP_SQ0;
                    phase_next = 1'b0;
                end
            end

            ST_MUL:
            begin
                if (!phase_reg)
                begin
                    unique case (op_reg)
                        OP_SQ0: begin mul_a = u_reg[0]; mul_b = u_reg[0]; end
                        OP_SQ1: begin mul_a = u_reg[1]; mul_b = u_reg[1]; end
                        OP_SQ2: begin mul_a = u_reg[2]; mul_b = u_reg[2]; end
                        OP_D0:  begin mul_a = Q30_ONE - tmp_reg[OP_SQ0]; mul_b = cs_reg; end
                        OP_D1:  begin mul_a = Q30_ONE - tmp_reg[OP_SQ1]; mul_b = cs_reg; end
                        OP_D2:  begin mul_a = Q30_ONE - tmp_reg[OP_SQ2]; mul_b = cs_reg; end
                        OP_P01: begin mul_a = u_reg[0]; mul_b = u_reg[1]; end
                        OP_P02: begin mul_a = u_reg[0]; mul_b = u_reg[2]; end
                        OP_P12: begin mul_a = u_reg[1]; mul_b = u_reg[2]; end
                        OP_A01: begin mul_a = tmp_reg[OP_P01]; mul_b = t_val; end
                        OP_A02: begin mul_a = tmp_reg[OP_P02]; mul_b = t_val; end
                        OP_A12: begin mul_a = tmp_reg[OP_P12]; mul_b = t_val; end
                        OP_S2:  begin mul_a = u_reg[2]; mul_b = sn_reg; end
                        OP_S1:  begin mul_a = u_reg[1]; mul_b = sn_reg; end
                        OP_S0:  begin mul_a = u_reg[0]; mul_b = sn_reg; end
                        default: begin mul_a = '0; mul_b = '0; end
                    endcase
                    phase_next = 1'b1;
                end
                else
                begin
                    tmp_wr     = 1'b1;
                    phase_next = 1'b0;
                    if (op_reg == OP_S0)
                    begin
                        state_next = ST_EMIT;
                        erow_next  = '0;
                    end
                    else
                    begin
                        op_next = aarm_op_t'(op_reg + 4'd1);
                    end
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || matrix.ready)
                begin
                    load_out  = 1'b1;
                    erow_next = erow_reg + 2'd1;
                    if (erow_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (matrix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        comp_reg  <= comp_next;
        erow_reg  <= erow_next;
        job_reg   <= job_next;
        prod_reg  <= mul_a * mul_b;
        sum_reg   <= sum_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        drem_reg  <= drem_next;
        dnum_reg  <= dnum_next;
        quo_reg   <= quo_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        cs_reg    <= cs_next;
        sn_reg    <= sn_next;
        if (u_wr)
        begin
            u_reg[comp_reg] <= u_val;
        end
        if (tmp_wr)
        begin
            tmp_reg[op_reg] <= prod_rnd[30+Q_W-1:30];
        end
    end

    // matrix entries from the product terms
    assign m00 = tmp_reg[OP_SQ0] + tmp_reg[OP_D0];
    assign m11 = tmp_reg[OP_SQ1] + tmp_reg[OP_D1];
    assign m22 = tmp_reg[OP_SQ2] + tmp_reg[OP_D2];
    assign m01 = tmp_reg[OP_A01] - tmp_reg[OP_S2];
    assign m10 = tmp_reg[OP_A01] + tmp_reg[OP_S2];
    assign m02 = tmp_reg[OP_A02] + tmp_reg[OP_S1];
    assign m20 = tmp_reg[OP_A02] - tmp_reg[OP_S1];
    assign m12 = tmp_reg[OP_A12] - tmp_reg[OP_S0];
    assign m21 = tmp_reg[OP_A12] + tmp_reg[OP_S0];

    always_comb
    begin
        unique case (erow_reg)
            2'd0:    begin e0 = m00; e1 = m01; e2 = m02; end
            2'd1:    begin e0 = m10; e1 = m11; e2 = m12; end
            2'd2:    begin e0 = m20; e1 = m21; e2 = m22; end
            default: begin e0 = '0;  e1 = '0;  e2 = '0;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            row_reg  <= erow_reg;
            zero_reg <= job_reg.zero;
            last_reg <= (erow_reg == 2'd3);
            if (erow_reg == 2'd3)
            begin
                c0_reg <= '0;
                c1_reg <= '0;
                c2_reg <= '0;
                c3_reg <= OUT_ONE;
            end
            else if (job_reg.zero)
            begin
                c0_reg <= (erow_reg == 2'd0) ? OUT_ONE : '0;
                c1_reg <= (erow_reg == 2'd1) ? OUT_ONE : '0;
                c2_reg <= (erow_reg == 2'd2) ? OUT_ONE : '0;
                c3_reg <= '0;
            end
            else
            begin
                c0_reg <= to_out(e0);
                c1_reg <= to_out(e1);
                c2_reg <= to_out(e2);
                c3_reg <= '0;
            end
        end
    end

    assign matrix.valid     = out_valid_reg;
    assign matrix.row_index = row_reg;
    assign matrix.col0      = c0_reg;
    assign matrix.col1      = c1_reg;
    assign matrix.col2      = c2_reg;
    assign matrix.col3      = c3_reg;
    assign matrix.zero_axis = zero_reg;
    assign matrix.last_row  = last_reg;

endmodule

[rtl/axis_angle_rotation_matrix.sv]
// Top level of the axis-angle (Rodrigues) 4x4 rotation matrix block.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------------
//  axis    | in  | valid / ready | axis_x, axis_y, axis_z (Q1.14), angle (Q3.13)
//  matrix  | out | valid / ready | row_index, col0..col3 (Q1.14), zero_axis, last_row
//
// Each request gives four row results, rows 0 to 3 in order.
// Back end occupancy per request is set by the bit-serial square root, three
// restoring divides, the CORDIC iterations and 15 products on one shared multiplier;
// a zero axis skips all of these. The front end and a two-entry queue take new
// requests meanwhile.
// Reset (rst_n, async low) clears control only; no clearing pass.
// Stalls on matrix hold the row register; the back end waits, the queue keeps filling.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    aarm_axis_if.sink   axis,
    aarm_row_if.source  matrix
);
    import aarm_pkg::*;

    // front end -> queue
    logic      fq_valid, fq_ready;
    aarm_job_t fq_job;

    // queue -> back end
    logic      qb_valid, qb_ready;
    aarm_job_t qb_job;

    // Classifies the request: zero axis, scaled magnitudes, folded angle
    aarm_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (axis),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // Lets the front end run ahead of the back end
    aarm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_job)
    );

    // Sequenced arithmetic and row output register
    aarm_back #(
        .DATA_WIDTH   (DATA_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .matrix    (matrix)
    );

endmodule
